@@ design/u8tok_pkg.sv @@
// ----------------------------------------------------------------------------
// u8tok_pkg
// Shared types, byte constants and the accent folding table of the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package u8tok_pkg;

  localparam logic [7:0] ContMin   = 8'h80;
  localparam logic [7:0] LeadTwo   = 8'hC0;
  localparam logic [7:0] LeadThree = 8'hE0;
  localparam logic [7:0] LeadFour  = 8'hF0;
  localparam logic [7:0] LeadFold  = 8'hC3;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CaseShift = 8'h20;

  localparam logic [1:0] LenEmpty = 2'd0;
  localparam logic [1:0] LenOne   = 2'd1;
  localparam logic [1:0] LenMany  = 2'd2;

  localparam logic [1:0] SkipTwo   = 2'd2;
  localparam logic [1:0] SkipThree = 2'd3;

  // Up to three characters from one item; slot 2 is always a token end.
  typedef struct packed {
    logic [2:0] mask;
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic [7:0] ch2;
  } bundle_t;

  function automatic logic [7:0] fold_second(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hA4: r = 8'h61;
      8'hA9, 8'hAA:                      r = 8'h65;
      8'hAC, 8'hAD, 8'hAE, 8'hAF:        r = 8'h69;
      8'hB2, 8'hB3, 8'hB4, 8'hB6:        r = 8'h6F;
      8'hBA, 8'hBB, 8'hBC:               r = 8'h75;
      8'hA7:                             r = 8'h63;
      8'hB1:                             r = 8'h6E;
      8'hBF:                             r = 8'h79;
      default:                           r = b;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/u8tok_decode.sv @@
// ----------------------------------------------------------------------------
// u8tok_decode
// Tokenizer state and the per-byte decode into up to three characters.
// ----------------------------------------------------------------------------
`default_nettype none

module u8tok_decode (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic [7:0]        text_byte,
  input  wire logic              end_of_text,
  output u8tok_pkg::bundle_t     res
);

  logic [7:0] held_char;
  logic [1:0] token_length;
  logic [1:0] bytes_to_skip;
  logic       lead_waiting;
  logic [7:0] lead_value;

  logic [7:0] held_char_next;
  logic [1:0] token_length_next;
  logic [1:0] bytes_to_skip_next;
  logic       lead_waiting_next;
  logic [7:0] lead_value_next;

  logic [1:0] n_app;
  logic [7:0] app0;
  logic [7:0] app1;
  logic       fin;
  logic       is_upper;
  logic       is_lower;
  logic       is_digit;
  logic [1:0] len1;
  logic [7:0] h1;
  logic [1:0] len2;
  logic [7:0] h2;
  logic       e0;
  logic       e1;
  logic       e2;

  always_comb begin
    n_app              = 2'd0;
    app0               = text_byte;
    app1               = text_byte;
    fin                = 1'b0;
    bytes_to_skip_next = bytes_to_skip;
    lead_waiting_next  = lead_waiting;
    lead_value_next    = lead_value;
    is_upper = (text_byte >= 8'h41) && (text_byte <= 8'h5A);
    is_lower = (text_byte >= 8'h61) && (text_byte <= 8'h7A);
    is_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
    if (bytes_to_skip != 2'd0) begin
      bytes_to_skip_next = bytes_to_skip - 2'd1;
    end else if (lead_waiting) begin
      lead_waiting_next = 1'b0;
      lead_value_next   = 8'h00;
      if (lead_value == u8tok_pkg::LeadFold) begin
        n_app = 2'd1;
        app0  = u8tok_pkg::fold_second(text_byte);
      end else begin
        n_app = 2'd2;
        app0  = lead_value;
        app1  = text_byte;
      end
    end else if (text_byte < u8tok_pkg::ContMin) begin
      if (is_upper) begin
        n_app = 2'd1;
        app0  = text_byte + u8tok_pkg::CaseShift;
      end else if (is_lower || is_digit || text_byte == u8tok_pkg::CharPlus ||
                   text_byte == u8tok_pkg::CharHash) begin
        n_app = 2'd1;
      end else begin
        fin = 1'b1;
      end
    end else if (text_byte < u8tok_pkg::LeadTwo) begin
      n_app = 2'd0;
    end else if (text_byte < u8tok_pkg::LeadThree) begin
      lead_waiting_next = 1'b1;
      lead_value_next   = text_byte;
    end else if (text_byte < u8tok_pkg::LeadFour) begin
      bytes_to_skip_next = u8tok_pkg::SkipTwo;
    end else begin
      bytes_to_skip_next = u8tok_pkg::SkipThree;
    end

    e0   = (n_app != 2'd0) && (token_length != u8tok_pkg::LenEmpty);
    len1 = token_length;
    h1   = held_char;
    if (n_app != 2'd0) begin
      len1 = (token_length == u8tok_pkg::LenEmpty) ? u8tok_pkg::LenOne : u8tok_pkg::LenMany;
      h1   = app0;
    end
    e1   = (n_app == 2'd2);
    len2 = e1 ? u8tok_pkg::LenMany : len1;
    h2   = e1 ? app1 : h1;
    e2   = (fin || end_of_text) && (len2 == u8tok_pkg::LenMany);

    token_length_next = len2;
    held_char_next    = h2;
    if (fin || end_of_text) begin
      token_length_next = u8tok_pkg::LenEmpty;
      held_char_next    = 8'h00;
    end
    if (end_of_text) begin
      bytes_to_skip_next = 2'd0;
      lead_waiting_next  = 1'b0;
      lead_value_next    = 8'h00;
    end

    res.mask = {e2, e1, e0};
    res.ch0  = held_char;
    res.ch1  = h1;
    res.ch2  = h2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_char     <= 8'h00;
      token_length  <= u8tok_pkg::LenEmpty;
      bytes_to_skip <= 2'd0;
      lead_waiting  <= 1'b0;
      lead_value    <= 8'h00;
    end else if (advance) begin
      held_char     <= held_char_next;
      token_length  <= token_length_next;
      bytes_to_skip <= bytes_to_skip_next;
      lead_waiting  <= lead_waiting_next;
      lead_value    <= lead_value_next;
    end
  end

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    token_length != 2'd3)
    else $error("token length out of range");

  a_lead_skip_excl: assert property (@(posedge clk) disable iff (rst)
    !(lead_waiting && bytes_to_skip != 2'd0))
    else $error("lead pending while skipping");

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    advance && end_of_text |=>
      token_length == u8tok_pkg::LenEmpty && bytes_to_skip == 2'd0 && !lead_waiting)
    else $error("state not cleared at end of text");

endmodule

`default_nettype wire

@@ design/u8tok_outq.sv @@
// ----------------------------------------------------------------------------
// u8tok_outq
// Result register for one item's characters, drained one per cycle when ready.
// ----------------------------------------------------------------------------
`default_nettype none

module u8tok_outq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire u8tok_pkg::bundle_t res,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             token_char,
  output logic                   token_end,
  output logic                   run_last
);

  logic [2:0] mask;
  logic [2:0] mask_next;
  logic [7:0] ch0;
  logic [7:0] ch1;
  logic [7:0] ch2;
  logic [2:0] lowest;
  logic       take;
  logic       single;

  always_comb begin
    lowest     = mask & (~mask + 3'd1);
    single     = (mask & (mask - 3'd1)) == 3'd0;
    out_valid  = (mask != 3'd0);
    take       = out_valid && out_ready;
    free       = !out_valid || (take && single);
    token_char = mask[0] ? ch0 : (mask[1] ? ch1 : ch2);
    token_end  = lowest[2];
    run_last   = out_valid && single;
    mask_next  = mask;
    if (take) begin
      mask_next = mask & ~lowest;
    end
    if (load) begin
      mask_next = res.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= 3'd0;
    end else begin
      mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ch0 <= res.ch0;
      ch1 <= res.ch1;
      ch2 <= res.ch2;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result register overwritten");

  a_drain_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !single && !load |=> out_valid)
    else $error("pending characters lost");

endmodule

`default_nettype wire

@@ design/utf8_accent_folding_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// utf8_accent_folding_tokenizer_core
// UTF-8 word tokenizer with lower-casing and accent folding.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle while the result register has room. A byte is
// registered, decoded combinationally into up to three token characters, and
// those go through a result register to the output, one per cycle while
// out_ready is high. The single output port sets the rate: bytes giving zero
// or one character sustain one byte per cycle while out_ready is high, and a
// byte giving more holds the input until its last character is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_accent_folding_tokenizer_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] text_byte,
  input  wire logic       end_of_text,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      token_char,
  output logic            token_end,
  output logic            run_last
);

  logic               hold_valid;
  logic               hold_valid_next;
  logic [7:0]         text_q;
  logic               last_q;
  logic               free;
  logic               consume;
  logic               accept;
  u8tok_pkg::bundle_t res;

  always_comb begin
    consume         = hold_valid && free;
    in_ready        = !hold_valid || consume;
    accept          = in_valid && in_ready;
    hold_valid_next = accept ? 1'b1 : (consume ? 1'b0 : hold_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      text_q <= text_byte;
      last_q <= end_of_text;
    end
  end

  u8tok_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .advance     (consume),
    .text_byte   (text_q),
    .end_of_text (last_q),
    .res         (res)
  );

  u8tok_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .load       (consume),
    .res        (res),
    .free       (free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .token_char (token_char),
    .token_end  (token_end),
    .run_last   (run_last)
  );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and checking for the UTF-8 accent folding tokenizer core.
// ----------------------------------------------------------------------------
// A fixed table of text bytes comes first. It walks through lower-casing,
// accent folding, skipped multi-byte sequences, stray continuation bytes,
// dropped one-character tokens and end of text. After it come random words,
// separators and noise. Every character the core emits is checked against an
// in-bench tokenizer model, except on the few table rows whose expected
// characters are written out by hand. Both handshakes idle in random bursts.
// ----------------------------------------------------------------------------

module testbench;

  localparam int RandBytes = 433;
  localparam int CycleLimit = 200000;

  localparam logic [7:0] ContFirst = 8'h80;
  localparam logic [7:0] ContLast = 8'hBF;
  localparam logic [7:0] PairFirst = 8'hC0;
  localparam logic [7:0] PairLast = 8'hDF;
  localparam logic [7:0] TripleFirst = 8'hE0;
  localparam logic [7:0] TripleLast = 8'hEF;
  localparam logic [7:0] QuadFirst = 8'hF0;
  localparam logic [7:0] FoldLead = 8'hC3;
  localparam logic [7:0] PlusChar = 8'h2B;
  localparam logic [7:0] HashChar = 8'h23;
  localparam logic [7:0] UpperToLower = 8'h20;

  localparam logic [1:0] LenEmpty = 2'd0;
  localparam logic [1:0] LenOne = 2'd1;
  localparam logic [1:0] LenMany = 2'd2;
  localparam logic [1:0] SkipPair = 2'd2;
  localparam logic [1:0] SkipTriple = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic tend;
    logic rlast;
  } token_char_t;

  typedef struct packed {
    logic [7:0] b;
    logic eot;
    logic typed;
    logic [1:0] n;
    logic [2:0][7:0] chars;
    logic [2:0] ends;
  } text_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [7:0] text_byte;
  logic end_of_text;
  logic out_valid;
  logic out_ready;
  logic [7:0] token_char;
  logic token_end;
  logic run_last;

  utf8_accent_folding_tokenizer_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .text_byte(text_byte),
    .end_of_text(end_of_text),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .token_char(token_char),
    .token_end(token_end),
    .run_last(run_last)
  );

  text_row_t text_q[$];
  token_char_t pending_chars[$];
  token_char_t step_chars[$];

  logic [7:0] held_q = 8'h00;
  logic [1:0] len_q = LenEmpty;
  logic [1:0] skip_q = 2'd0;
  logic lead_q = 1'b0;
  logic [7:0] lead_val_q = 8'h00;

  int faults = 0;
  int bytes_sent = 0;
  int chars_seen = 0;
  int tokens_seen = 0;
  int cycles = 0;
  bit calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit is_word_byte(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b >= "0" && b <= "9") ||
           b == PlusChar || b == HashChar;
  endfunction

  function automatic logic [7:0] accent_base(input logic [7:0] b);
    case (b)
      8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hA4: return "a";
      8'hA9, 8'hAA: return "e";
      8'hAC, 8'hAD, 8'hAE, 8'hAF: return "i";
      8'hB2, 8'hB3, 8'hB4, 8'hB6: return "o";
      8'hBA, 8'hBB, 8'hBC: return "u";
      8'hA7: return "c";
      8'hB1: return "n";
      8'hBF: return "y";
      default: return b;
    endcase
  endfunction

  // hold the newest character back; release the previous one
  function void append_char(input logic [7:0] ch);
    if (len_q == LenEmpty) begin
      len_q = LenOne;
    end else begin
      step_chars = {step_chars, token_char_t'({held_q, 1'b0, 1'b0})};
      len_q = LenMany;
    end
    held_q = ch;
  endfunction

  function void close_token();
    if (len_q == LenMany) step_chars = {step_chars, token_char_t'({held_q, 1'b1, 1'b0})};
    len_q = LenEmpty;
    held_q = 8'h00;
  endfunction

  function void tokenize(input logic [7:0] b, input logic eot);
    step_chars.delete();
    if (skip_q != 2'd0) begin
      skip_q = skip_q - 2'd1;
    end else if (lead_q) begin
      lead_q = 1'b0;
      if (lead_val_q == FoldLead) begin
        append_char(accent_base(b));
      end else begin
        append_char(lead_val_q);
        append_char(b);
      end
      lead_val_q = 8'h00;
    end else if (b < ContFirst) begin
      if (b >= "A" && b <= "Z") append_char(b + UpperToLower);
      else if (is_word_byte(b)) append_char(b);
      else close_token();
    end else if (b < PairFirst) begin
      // drop stray continuation byte
    end else if (b < TripleFirst) begin
      lead_q = 1'b1;
      lead_val_q = b;
    end else if (b < QuadFirst) begin
      skip_q = SkipPair;
    end else begin
      skip_q = SkipTriple;
    end
    if (eot) begin
      close_token();
      skip_q = 2'd0;
      lead_q = 1'b0;
      lead_val_q = 8'h00;
    end
    if (step_chars.size() > 0) step_chars[step_chars.size() - 1].rlast = 1'b1;
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic eot);
    text_row_t r;
    r = '0;
    r.b = b;
    r.eot = eot;
    text_q = {text_q, r};
  endtask

  task automatic queue_typed(input logic [7:0] b, input logic eot, input logic [1:0] n,
                             input logic [7:0] c0, input logic e0, input logic [7:0] c1,
                             input logic e1, input logic [7:0] c2, input logic e2);
    text_row_t r;
    r = '0;
    r.b = b;
    r.eot = eot;
    r.typed = 1'b1;
    r.n = n;
    r.chars = {c2, c1, c0};
    r.ends = {e2, e1, e0};
    text_q = {text_q, r};
  endtask

  task automatic queue_random_byte(input logic [7:0] b);
    queue_byte(b, $urandom_range(0, 39) == 0);
  endtask

  // mostly well-formed words with a separator, some raw noise
  task automatic queue_text();
    int count;
    logic [7:0] b;
    if ($urandom_range(0, 6) == 0) begin
      count = $urandom_range(1, 4);
      repeat (count) queue_random_byte(8'($urandom_range(0, 255)));
    end else begin
      count = $urandom_range(1, 7);
      repeat (count) begin
        case ($urandom_range(0, 9))
          0, 1: queue_random_byte(8'("a" + $urandom_range(0, 25)));
          2: queue_random_byte(8'("A" + $urandom_range(0, 25)));
          3: queue_random_byte(8'("0" + $urandom_range(0, 9)));
          4: queue_random_byte($urandom_range(0, 1) ? PlusChar : HashChar);
          5, 6: begin
            queue_random_byte(FoldLead);
            queue_random_byte(8'($urandom_range(ContFirst, ContLast)));
          end
          7: begin
            queue_random_byte(8'($urandom_range(PairFirst, PairLast)));
            queue_random_byte(8'($urandom_range(0, 255)));
          end
          8: begin
            queue_random_byte(8'($urandom_range(TripleFirst, TripleLast)));
            repeat (2) queue_random_byte(8'($urandom_range(ContFirst, ContLast)));
          end
          default: begin
            queue_random_byte(8'($urandom_range(QuadFirst, 8'hFF)));
            repeat (3) queue_random_byte(8'($urandom_range(ContFirst, ContLast)));
          end
        endcase
      end
      do b = 8'($urandom_range(0, 127)); while (is_word_byte(b));
      queue_random_byte(b);
    end
  endtask

  task automatic send_row(input text_row_t r, input bit may_idle);
    int i;
    if (may_idle && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= r.b;
    end_of_text <= r.eot;
    do @(posedge clk); while (!in_ready);
    tokenize(r.b, r.eot);
    bytes_sent++;
    if (r.typed) begin
      for (i = 0; i < r.n; i++) begin
        pending_chars = {pending_chars,
                         token_char_t'({r.chars[i], r.ends[i], i == r.n - 1})};
      end
    end else begin
      pending_chars = {pending_chars, step_chars};
    end
  endtask

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
        if ($urandom_range(0, 2) != 0) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 17)) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    token_char_t want;
    if (!rst && out_valid && out_ready) begin
      chars_seen++;
      if (token_end) tokens_seen++;
      if (pending_chars.size() == 0) begin
        faults++;
        $display("%0t: unexpected character, expected none, got %h end %b last %b",
                 $time, token_char, token_end, run_last);
      end else begin
        want = pending_chars.pop_front();
        if (token_char !== want.ch) begin
          faults++;
          $display("%0t: token_char expected %h, got %h", $time, want.ch, token_char);
        end
        if (token_end !== want.tend) begin
          faults++;
          $display("%0t: token_end expected %b, got %b", $time, want.tend, token_end);
        end
        if (run_last !== want.rlast) begin
          faults++;
          $display("%0t: run_last expected %b, got %b", $time, want.rlast, run_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("%0t: timeout, %0d characters still awaited", $time, pending_chars.size());
      $display("[utf8_accent_folding_tokenizer_core] ERROR");
      $finish;
    end
  end

  initial begin
    int idx;
    rst = 1'b1;
    in_valid = 1'b0;
    text_byte = 8'h00;
    end_of_text = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    queue_typed("A", 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    queue_typed("z", 1'b0, 2'd1, "a", 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    queue_byte(FoldLead, 1'b0);
    queue_byte(8'hA1, 1'b0);
    queue_byte(FoldLead, 1'b0);
    queue_byte(8'hA7, 1'b0);
    queue_typed(8'h7F, 1'b0, 2'd1, "c", 1'b1, 8'h00, 1'b0, 8'h00, 1'b0);
    queue_typed("Q", 1'b1, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    queue_typed(8'h00, 1'b0, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    queue_byte(PlusChar, 1'b0);
    queue_byte(HashChar, 1'b0);
    queue_byte(8'hE2, 1'b0);
    queue_byte(8'h82, 1'b0);
    queue_byte(8'hAC, 1'b0);
    queue_byte("9", 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hBF, 1'b0);
    queue_byte(8'h9F, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(PairLast, 1'b0);
    queue_typed(8'hFF, 1'b1, 2'd3, "9", 1'b0, PairLast, 1'b0, 8'hFF, 1'b1);
    queue_byte("x", 1'b0);
    queue_byte(FoldLead, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte("y", 1'b0);
    queue_typed(FoldLead, 1'b1, 2'd1, "y", 1'b1, 8'h00, 1'b0, 8'h00, 1'b0);
    while (text_q.size() != 0) send_row(text_q.pop_front(), 1'b1);

    for (idx = 0; idx < RandBytes; idx++) begin
      if (text_q.size() == 0) queue_text();
      if (idx == RandBytes / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_chars.size() != 0);
      end
      calm = (idx >= RandBytes - 60);
      send_row(text_q.pop_front(), !calm && !(idx >= 100 && idx < 160));
    end
    in_valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d text bytes; checked %0d token characters closing %0d tokens.",
             bytes_sent, chars_seen, tokens_seen);
    if (faults == 0) begin
      $display("[utf8_accent_folding_tokenizer_core] OK");
    end else begin
      $display("[utf8_accent_folding_tokenizer_core] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/u8tok_pkg.sv
design/u8tok_decode.sv
design/u8tok_outq.sv
design/utf8_accent_folding_tokenizer_core.sv
tb/testbench.sv
